// File: hw/rtl/assert_macros.svh
// assertion macros shared by the window level colormap rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define WLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// pre at one edge implies post at the next edge
`define WLC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define WLC_ASSERT(lbl, prop, msg)
`define WLC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hw/rtl/wlc_pkg.sv
// types and constants of the window level colormap block
package wlc_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FLOOR_BITS     = 16;
    localparam int GAIN_BITS      = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int TABLE_ENTRIES  = 256;
    localparam int IDX_W          = $clog2(TABLE_ENTRIES);
    localparam int COLOR_W        = 8;

    // sample minus floor keeps one extra bit so it never wraps
    localparam int DIFF_W  = ((SAMPLE_BITS > FLOOR_BITS) ? SAMPLE_BITS : FLOOR_BITS) + 1;
    localparam int MAG_W   = DIFF_W - 1;
    localparam int PROD_W  = MAG_W + GAIN_BITS;
    localparam int SAT_LSB = GAIN_FRAC_BITS + IDX_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_BITS;

    // both queue depths are powers of two, pointers wrap on their own
    localparam int MIDQ_DEPTH = 8;
    localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
    localparam int MIDQ_CW    = $clog2(MIDQ_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_AW     = $clog2(OUT_DEPTH);
    localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_FLOOR = 2'd0,
        REG_SCALE_GAIN   = 2'd1
    } t_reg_idx;

    typedef enum logic {
        ACT_PIXEL       = 1'b0,
        ACT_ENTRY_WRITE = 1'b1
    } t_action;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    // one classified request between front and back
    typedef struct packed {
        t_action          action;
        logic [IDX_W-1:0] index;
        t_rgb             rgb;
    } t_cmd;

    typedef struct packed {
        logic               empty;
        logic [MIDQ_CW-1:0] count;
    } t_q_status;

    typedef struct packed {
        t_rgb             rgb;
        logic [IDX_W-1:0] index;
    } t_pix;

endpackage

// File: hw/rtl/window_level_colormap_top.sv
// top level of the window level colormap block
//
// channel   direction  handshake                     payload
// input     in         i_push / o_full               i_action, i_sample, i_entry_*
// result    out        o_empty / i_pop               o_red, o_green, o_blue, o_display_index
// config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// one request per cycle sustained while o_full is low
// pixel path: subtract stage, gain multiplier stage, request queue, table read, result queue
// table writes give no result and take one back end slot in request order
// reset clears pointers and the table valid bits, tables then read as the gray ramp
// o_full rises when the 8 entry request queue is spoken for; the back end stalls on a full
// 4 entry result queue, so results left waiting on i_pop stop new requests once both fill
module window_level_colormap_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic                                   i_action,
    input  logic signed [wlc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [wlc_pkg::IDX_W-1:0]              i_entry_index,
    input  logic [wlc_pkg::COLOR_W-1:0]            i_entry_red,
    input  logic [wlc_pkg::COLOR_W-1:0]            i_entry_green,
    input  logic [wlc_pkg::COLOR_W-1:0]            i_entry_blue,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic [wlc_pkg::COLOR_W-1:0]            o_red,
    output logic [wlc_pkg::COLOR_W-1:0]            o_green,
    output logic [wlc_pkg::COLOR_W-1:0]            o_blue,
    output logic [wlc_pkg::IDX_W-1:0]              o_display_index,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [wlc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [wlc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    logic signed [wlc_pkg::FLOOR_BITS-1:0] r_window_floor;
    logic [wlc_pkg::GAIN_BITS-1:0]         r_scale_gain;
    logic                                  w_cfg_wr;
    wlc_pkg::t_q_status                    w_q_status;
    logic                                  w_q_push;
    logic                                  w_q_pop;
    wlc_pkg::t_cmd                         w_front_cmd;
    wlc_pkg::t_cmd                         w_back_cmd;
    wlc_pkg::t_pix                         w_pix;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_floor <= '0;
            r_scale_gain   <= wlc_pkg::GAIN_BITS'(1) << wlc_pkg::GAIN_FRAC_BITS;
        end else if (w_cfg_wr) begin
            case (wlc_pkg::t_reg_idx'(i_cfg_index))
                wlc_pkg::REG_WINDOW_FLOOR: r_window_floor <= i_cfg_data[wlc_pkg::FLOOR_BITS-1:0];
                wlc_pkg::REG_SCALE_GAIN:   r_scale_gain   <= i_cfg_data[wlc_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    wlc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_action       (i_action),
        .i_sample       (i_sample),
        .i_entry_index  (i_entry_index),
        .i_entry_red    (i_entry_red),
        .i_entry_green  (i_entry_green),
        .i_entry_blue   (i_entry_blue),
        .i_window_floor (r_window_floor),
        .i_scale_gain   (r_scale_gain),
        .i_q_status     (w_q_status),
        .o_q_push       (w_q_push),
        .o_q_cmd        (w_front_cmd)
    );

    wlc_midq u_midq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_q_pop),
        .o_cmd    (w_back_cmd),
        .o_status (w_q_status)
    );

    wlc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_cmd      (w_back_cmd),
        .o_q_pop    (w_q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_pix      (w_pix)
    );

    assign o_red           = w_pix.rgb.red;
    assign o_green         = w_pix.rgb.green;
    assign o_blue          = w_pix.rgb.blue;
    assign o_display_index = w_pix.index;

endmodule

// File: hw/rtl/wlc_front.sv
// front end: accepts requests, windows and scales the sample, clamps the index
module wlc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic                                 i_action,
    input  logic signed [wlc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [wlc_pkg::IDX_W-1:0]            i_entry_index,
    input  logic [wlc_pkg::COLOR_W-1:0]          i_entry_red,
    input  logic [wlc_pkg::COLOR_W-1:0]          i_entry_green,
    input  logic [wlc_pkg::COLOR_W-1:0]          i_entry_blue,
    input  logic signed [wlc_pkg::FLOOR_BITS-1:0] i_window_floor,
    input  logic [wlc_pkg::GAIN_BITS-1:0]        i_scale_gain,
    input  wlc_pkg::t_q_status                   i_q_status,
    output logic                                 o_q_push,
    output wlc_pkg::t_cmd                        o_q_cmd
);

    logic                                r_f1_valid;
    logic                                n_f1_valid;
    wlc_pkg::t_cmd                       r_f1_cmd;
    logic signed [wlc_pkg::DIFF_W-1:0]   r_f1_diff;
    logic signed [wlc_pkg::DIFF_W-1:0]   n_f1_diff;
    logic                                r_f2_valid;
    wlc_pkg::t_cmd                       r_f2_cmd;
    logic [wlc_pkg::PROD_W-1:0]          r_f2_prod;
    logic [wlc_pkg::PROD_W-1:0]          n_f2_prod;
    logic [wlc_pkg::MAG_W-1:0]           w_mag;
    logic                                w_positive;
    logic [wlc_pkg::MIDQ_CW-1:0]         w_used;
    logic [wlc_pkg::IDX_W-1:0]           w_index;

    // slots already promised to the queue: its fill plus both stages
    assign w_used = i_q_status.count + wlc_pkg::MIDQ_CW'(r_f1_valid)
                  + wlc_pkg::MIDQ_CW'(r_f2_valid);
    assign o_full = (w_used >= wlc_pkg::MIDQ_CW'(wlc_pkg::MIDQ_DEPTH));
    assign n_f1_valid = i_push && !o_full;

    assign n_f1_diff =
        {{(wlc_pkg::DIFF_W-wlc_pkg::SAMPLE_BITS){i_sample[wlc_pkg::SAMPLE_BITS-1]}}, i_sample}
      - {{(wlc_pkg::DIFF_W-wlc_pkg::FLOOR_BITS){i_window_floor[wlc_pkg::FLOOR_BITS-1]}},
         i_window_floor};

    assign w_positive = !r_f1_diff[wlc_pkg::DIFF_W-1] && (r_f1_diff != '0);
    assign w_mag      = r_f1_diff[wlc_pkg::MAG_W-1:0];
    assign n_f2_prod  = w_positive
        ? ({{wlc_pkg::GAIN_BITS{1'b0}}, w_mag} * {{wlc_pkg::MAG_W{1'b0}}, i_scale_gain})
        : '0;

    // floor is the shift, anything above the index field saturates
    assign w_index = (|r_f2_prod[wlc_pkg::PROD_W-1:wlc_pkg::SAT_LSB])
        ? {wlc_pkg::IDX_W{1'b1}}
        : r_f2_prod[wlc_pkg::SAT_LSB-1:wlc_pkg::GAIN_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= n_f1_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_cmd.action    <= wlc_pkg::t_action'(i_action);
        r_f1_cmd.index     <= i_entry_index;
        r_f1_cmd.rgb.red   <= i_entry_red;
        r_f1_cmd.rgb.green <= i_entry_green;
        r_f1_cmd.rgb.blue  <= i_entry_blue;
        r_f1_diff          <= n_f1_diff;
        r_f2_cmd           <= r_f1_cmd;
        r_f2_prod          <= n_f2_prod;
    end

    always_comb begin
        o_q_cmd = r_f2_cmd;
        if (r_f2_cmd.action == wlc_pkg::ACT_PIXEL) begin
            o_q_cmd.index = w_index;
        end
    end
    assign o_q_push = r_f2_valid;

endmodule

// File: hw/rtl/wlc_midq.sv
// short request queue between the front end and the table back end
module wlc_midq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wlc_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output wlc_pkg::t_cmd      o_cmd,
    output wlc_pkg::t_q_status o_status
);

    wlc_pkg::t_cmd               r_mem [wlc_pkg::MIDQ_DEPTH];
    logic [wlc_pkg::MIDQ_AW-1:0] r_wptr;
    logic [wlc_pkg::MIDQ_AW-1:0] r_rptr;
    logic [wlc_pkg::MIDQ_CW-1:0] r_count;
    logic [wlc_pkg::MIDQ_CW-1:0] n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

// File: hw/rtl/wlc_back.sv
// back end: colormap tables with identity reset, lookup and result queue
`include "assert_macros.svh"

module wlc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wlc_pkg::t_q_status i_q_status,
    input  wlc_pkg::t_cmd      i_cmd,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output wlc_pkg::t_pix      o_pix
);

    wlc_pkg::t_rgb                     r_table [wlc_pkg::TABLE_ENTRIES];
    logic [wlc_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic                              r_b1_valid;
    logic [wlc_pkg::IDX_W-1:0]         r_rd_idx;
    wlc_pkg::t_rgb                     r_rd_data;
    logic                              r_rd_hit;
    wlc_pkg::t_pix                     r_out_mem [wlc_pkg::OUT_DEPTH];
    logic [wlc_pkg::OUT_AW-1:0]        r_out_wptr;
    logic [wlc_pkg::OUT_AW-1:0]        r_out_rptr;
    logic [wlc_pkg::OUT_CW-1:0]        r_out_count;
    logic [wlc_pkg::OUT_CW-1:0]        n_out_count;
    logic [wlc_pkg::OUT_CW-1:0]        w_out_used;
    logic                              w_is_pixel;
    logic                              w_is_write;
    logic                              w_out_pop;
    wlc_pkg::t_pix                     w_b1_pix;

    // a popped pixel request keeps a result slot; a table write takes none
    assign w_out_used = r_out_count + wlc_pkg::OUT_CW'(r_b1_valid);
    assign o_q_pop    = !i_q_status.empty
                     && (w_out_used < wlc_pkg::OUT_CW'(wlc_pkg::OUT_DEPTH));
    assign w_is_pixel = o_q_pop && (i_cmd.action == wlc_pkg::ACT_PIXEL);
    assign w_is_write = o_q_pop && (i_cmd.action == wlc_pkg::ACT_ENTRY_WRITE);

    always_ff @(posedge i_clk) begin
        if (w_is_write) begin
            r_table[i_cmd.index] <= i_cmd.rgb;
        end
        r_rd_data <= r_table[i_cmd.index];
        r_rd_hit  <= r_valid[i_cmd.index];
        r_rd_idx  <= i_cmd.index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_b1_valid <= 1'b0;
        end else begin
            r_b1_valid <= w_is_pixel;
            if (w_is_write) begin
                r_valid[i_cmd.index] <= 1'b1;
            end
        end
    end

    // an entry never written still holds the gray ramp
    always_comb begin
        w_b1_pix.index = r_rd_idx;
        if (r_rd_hit) begin
            w_b1_pix.rgb = r_rd_data;
        end else begin
            w_b1_pix.rgb.red   = r_rd_idx;
            w_b1_pix.rgb.green = r_rd_idx;
            w_b1_pix.rgb.blue  = r_rd_idx;
        end
    end

    assign w_out_pop = i_pop && !o_empty;

    always_comb begin
        n_out_count = r_out_count;
        case ({r_b1_valid, w_out_pop})
            2'b10:   n_out_count = r_out_count + 1'b1;
            2'b01:   n_out_count = r_out_count - 1'b1;
            default: n_out_count = r_out_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wptr  <= '0;
            r_out_rptr  <= '0;
            r_out_count <= '0;
        end else begin
            r_out_count <= n_out_count;
            if (r_b1_valid) begin
                r_out_wptr <= r_out_wptr + 1'b1;
            end
            if (w_out_pop) begin
                r_out_rptr <= r_out_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b1_valid) begin
            r_out_mem[r_out_wptr] <= w_b1_pix;
        end
    end

    assign o_empty = (r_out_count == '0);
    assign o_pix   = r_out_mem[r_out_rptr];

    `WLC_ASSERT(a_out_room, r_b1_valid |-> (r_out_count < wlc_pkg::OUT_CW'(wlc_pkg::OUT_DEPTH)), "lookup result found the result queue full")
    `WLC_ASSERT_NEXT(a_entry_marked, w_is_write, r_valid[$past(i_cmd.index)], "table write left its entry unmarked")
    `WLC_ASSERT_NEXT(a_pixel_lookup, w_is_pixel, r_b1_valid && (r_rd_idx == $past(i_cmd.index)), "pixel request lost on its way to the lookup stage")

endmodule
